/* sv/pvn_pkg.sv */
// ----------------------------------------------------------------------------
// pvn_pkg
// Types and constants for the vector normaliser.
// ----------------------------------------------------------------------------
package pvn_pkg;

	localparam int SAMPLE_W = 32;
	localparam int SUM_W    = 38;
	localparam int DEV_W    = 33;
	localparam int SQ_W     = 64;
	localparam int QSUM_W   = 70;
	localparam int NQ_W     = 78;
	localparam int ROOT_W   = 40;
	localparam int QUOT_W   = 63;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_DIV,
		ST_VAR_RD,
		ST_VAR_ACC,
		ST_NQ,
		ST_SQRT,
		ST_EMIT_RD,
		ST_EMIT_DIV,
		ST_EMIT_OUT
	} state_t;

	// start request and finish report of the shared divider
	typedef struct packed {
		logic                 start;
		logic [QUOT_W-1:0]    num;
		logic [ROOT_W-1:0]    den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [QUOT_W-1:0]    quot;
	} div_rsp_t;

endpackage

/* sv/pearson_vector_normalizer_top.sv */
// ----------------------------------------------------------------------------
// pearson_vector_normalizer_top
// Stores a vector of Q16.16 samples and emits each as (x-mean)/(sd*n), Q1.30.
// ----------------------------------------------------------------------------
// channel  | handshake           | payload
// input    | start / busy        | sample, last_sample
// result   | valid (1 cycle)     | normalized, zero_spread, last_result
//
// A sample without mark is only stored and summed. The marked sample starts
// the computation: mean divide, variance pass (a read and an accumulate
// per sample), n*Q, square root, then per sample a read, a divide and an
// output, each divide on the shared serial divider. busy is high
// throughout. No clearing pass after reset; results cannot be stalled.
module pearson_vector_normalizer_top #(
	parameter int MAX_SAMPLES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] sample,
	input  logic        last_sample,
	output logic        valid,
	output logic [31:0] normalized,
	output logic        zero_spread,
	output logic        last_result
);
	import pvn_pkg::*;

	localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CW = $clog2(MAX_SAMPLES + 1);

	logic [SAMPLE_W-1:0] mem [MAX_SAMPLES];
	logic [SAMPLE_W-1:0] rd_data;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;

	state_t state_q, state_d;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      idx_q;
	logic [SUM_W-1:0]   sum_q;
	logic [SUM_W-1:0]   mean_q;
	logic [QSUM_W-1:0]  qsum_q;
	logic [NQ_W-1:0]    nq_q;
	logic [ROOT_W-1:0]  root_q;
	logic               flat_q;
	logic               sq_go_q;

	div_req_t div_req;
	div_rsp_t div_rsp;
	logic sq_start, sq_done;
	logic [ROOT_W-1:0] sq_root;

	logic accept, full;
	logic [SUM_W-1:0]  sum_nxt;
	logic [CW-1:0]     cnt_nxt;
	logic [SUM_W-1:0]  sum_abs;
	logic [SUM_W-1:0]  mean_signed;
	logic [DEV_W-1:0]  dev;
	logic [DEV_W-1:0]  dev_abs;
	logic [SQ_W-1:0]   sq;
	logic [QUOT_W-1:0] t;
	logic [31:0]       sat;
	logic              emit_last;

	assign accept = start && !busy;
	assign full   = (count_q == CW'(MAX_SAMPLES));

	// sample store: one write port, registered read
	always_ff @(posedge clk) begin
		if (accept && !full) begin
			mem[count_q[AW-1:0]] <= sample;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
	assign rd_addr = idx_q[AW-1:0];

	// sum and count including the item being accepted, unless the store is full
	assign sum_nxt     = full ? sum_q : sum_q + SUM_W'($signed(sample));
	assign cnt_nxt     = full ? count_q : count_q + 1'b1;
	assign sum_abs     = sum_nxt[SUM_W-1] ? -sum_nxt : sum_nxt;
	assign mean_signed = sum_q[SUM_W-1] ? -(SUM_W'(div_rsp.quot)) : SUM_W'(div_rsp.quot);
	assign dev     = DEV_W'($signed(rd_data)) - DEV_W'(mean_q);
	assign dev_abs = dev[DEV_W-1] ? -dev : dev;
	assign sq      = SQ_W'(dev_abs) * SQ_W'(dev_abs);
	assign t       = div_rsp.quot;
	assign emit_last = (idx_q == count_q);

	always_comb begin
		if (dev[DEV_W-1]) begin
			sat = (t > QUOT_W'(32'h8000_0000)) ? 32'h8000_0000 : -t[31:0];
		end else begin
			sat = (t > QUOT_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : t[31:0];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:     if (accept && last_sample) state_d = ST_DIV;
			ST_DIV:      if (div_rsp.done) state_d = ST_VAR_RD;
			ST_VAR_RD:   state_d = ST_VAR_ACC;
			ST_VAR_ACC:  state_d = emit_last ? ST_NQ : ST_VAR_RD;
			ST_NQ:       state_d = ST_SQRT;
			ST_SQRT:     if (sq_done) state_d = ST_EMIT_RD;
			ST_EMIT_RD:  state_d = ST_EMIT_DIV;
			ST_EMIT_DIV: if (div_rsp.done) state_d = ST_EMIT_OUT;
			ST_EMIT_OUT: state_d = emit_last ? ST_LOAD : ST_EMIT_RD;
			default:     state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		rd_en        = (state_q == ST_VAR_RD) || (state_q == ST_EMIT_RD);
		sq_start     = sq_go_q;
		div_req.start = 1'b0;
		div_req.num  = '0;
		div_req.den  = '0;
		if (state_q == ST_LOAD && accept && last_sample) begin
			div_req.start = 1'b1;
			div_req.num   = QUOT_W'(sum_abs);
			div_req.den   = ROOT_W'(cnt_nxt);
		end
	end

	// the divider is started from a registered request in the emit phase
	logic emit_go_q;
	div_req_t req_mux;
	always_comb begin
		req_mux = div_req;
		if (emit_go_q) begin
			req_mux.start = 1'b1;
			req_mux.num   = QUOT_W'({dev_abs, 30'b0});
			req_mux.den   = root_q;
		end
	end

	pvn_divider u_div (.clk, .arst_n, .req(req_mux), .rsp(div_rsp));
	pvn_sqrt u_sqrt (.clk, .arst_n, .start(sq_start), .radicand(nq_q),
		.done(sq_done), .root(sq_root));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			idx_q     <= '0;
			sum_q     <= '0;
			valid     <= 1'b0;
			emit_go_q <= 1'b0;
			sq_go_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			valid     <= 1'b0;
			emit_go_q <= 1'b0;
			// n*Q is registered first, so the root starts only once n*Q is registered
			sq_go_q   <= (state_q == ST_NQ);
			unique case (state_q)
				ST_LOAD: begin
					// the divide starts from a sum that already includes the marked sample
					if (accept) begin
						count_q <= cnt_nxt;
						sum_q   <= sum_nxt;
					end
					idx_q <= '0;
				end
				ST_VAR_ACC: idx_q <= emit_last ? CW'(0) : idx_q;
				ST_VAR_RD:  idx_q <= idx_q + 1'b1;
				ST_EMIT_RD: begin
					idx_q     <= idx_q + 1'b1;
					emit_go_q <= 1'b1;
				end
				ST_EMIT_OUT: begin
					valid <= 1'b1;
					if (emit_last) begin
						count_q <= '0;
						sum_q   <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_LOAD:    qsum_q <= '0;
			ST_DIV:     if (div_rsp.done) mean_q <= mean_signed;
			ST_VAR_ACC: qsum_q <= qsum_q + QSUM_W'(sq);
			ST_NQ: begin
				nq_q   <= NQ_W'(qsum_q) * NQ_W'(count_q);
				flat_q <= (qsum_q == '0);
			end
			ST_SQRT:    if (sq_done) root_q <= sq_root;
			ST_EMIT_DIV: ;
			ST_EMIT_OUT: begin
				normalized  <= (flat_q || root_q == '0) ? 32'h0 : sat;
				zero_spread <= flat_q;
				last_result <= emit_last;
			end
			default: ;
		endcase
	end

	assign busy = (state_q != ST_LOAD);

endmodule

/* sv/pvn_divider.sv */
// ----------------------------------------------------------------------------
// pvn_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pvn_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  pvn_pkg::div_req_t req,
	output pvn_pkg::div_rsp_t rsp
);
	import pvn_pkg::*;

	localparam int CNT_W = $clog2(QUOT_W + 1);

	logic [QUOT_W-1:0] quot_q;
	logic [ROOT_W:0]   rem_q;
	logic [ROOT_W-1:0] den_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [ROOT_W:0]   trial;

	assign trial = {rem_q[ROOT_W-1:0], quot_q[QUOT_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.num;
			rem_q  <= '0;
			den_q  <= req.den;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q  <= trial - {1'b0, den_q};
				quot_q <= {quot_q[QUOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= trial;
				quot_q <= {quot_q[QUOT_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

/* sv/pvn_sqrt.sv */
// ----------------------------------------------------------------------------
// pvn_sqrt
// Floor square root, one result bit per cycle (digit recurrence).
// ----------------------------------------------------------------------------
module pvn_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pvn_pkg::NQ_W-1:0]   radicand,
	output logic                       done,
	output logic [pvn_pkg::ROOT_W-1:0] root
);
	import pvn_pkg::*;

	localparam int CNT_W = $clog2(ROOT_W + 1);
	localparam int REM_W = ROOT_W + 2;

	logic [2*ROOT_W-1:0] rad_q;
	logic [REM_W-1:0]    rem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [REM_W-1:0]    rem_sh;
	logic [REM_W-1:0]    tst;

	assign rem_sh = {rem_q[REM_W-3:0], rad_q[2*ROOT_W-1 -: 2]};
	assign tst    = {root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= {{(2*ROOT_W-NQ_W){1'b0}}, radicand};
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[2*ROOT_W-3:0], 2'b00};
			if (rem_sh >= tst) begin
				rem_q  <= rem_sh - tst;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

/* test/tb_pearson_vector_normalizer_top.sv */
// ----------------------------------------------------------------------------
// tb_pearson_vector_normalizer_top
// Feeds sample vectors through the normaliser and checks each emitted value.
// The expected values come from a bit-exact model of the mean, spread and
// divide kept alongside. The input side idles at random.
// ----------------------------------------------------------------------------
module tb_pearson_vector_normalizer_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_N = 64;

	typedef struct {
		logic [31:0] x;
		logic        mark;
		logic        pause;
	} sample_item_t;

	typedef struct {
		logic [31:0] norm;
		logic        flat;
		logic        final_one;
	} norm_value_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] sample;
	logic        last_sample;
	logic        valid;
	logic [31:0] normalized;
	logic        zero_spread;
	logic        last_result;

	sample_item_t pending_samples[$];
	norm_value_t  expected_values[$];
	int           n_accepted;
	int           n_errors;
	bit           stim_done;

	// model state
	logic [31:0] vec_store[MAX_N];
	int          vec_count;
	longint      vec_sum;

	pearson_vector_normalizer_top #(.MAX_SAMPLES(MAX_N)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sample(sample), .last_sample(last_sample), .valid(valid),
		.normalized(normalized), .zero_spread(zero_spread),
		.last_result(last_result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic logic [127:0] floor_root(logic [127:0] v);
		logic [127:0] r;
		logic [127:0] c;
		r = '0;
		for (int b = 39; b >= 0; b--) begin
			c = r | (128'd1 << b);
			if (c * c <= v)
				r = c;
		end
		return r;
	endfunction

	// absorb one sample; on the mark, queue the whole normalised vector
	task automatic take_sample(logic [31:0] x, logic mark);
		longint       mean;
		longint       d;
		logic [127:0] qsum;
		logic [127:0] root;
		logic [127:0] t;
		logic [127:0] m;
		norm_value_t  v;
		if (vec_count < MAX_N) begin
			vec_store[vec_count] = x;
			vec_count++;
			vec_sum += longint'(signed'(x));
		end
		if (!mark)
			return;
		mean = vec_sum / vec_count;
		qsum = '0;
		for (int i = 0; i < vec_count; i++) begin
			d = longint'(signed'(vec_store[i])) - mean;
			m = (d < 0) ? -d : d;
			qsum += m * m;
		end
		root = floor_root(qsum * vec_count);
		for (int i = 0; i < vec_count; i++) begin
			v.norm = '0;
			if (qsum != 0 && root != 0) begin
				d = longint'(signed'(vec_store[i])) - mean;
				m = (d < 0) ? -d : d;
				t = (m << 30) / root;
				if (d < 0) begin
					if (t > 128'h8000_0000)
						t = 128'h8000_0000;
					v.norm = -t[31:0];
				end else begin
					if (t > 128'h7FFF_FFFF)
						t = 128'h7FFF_FFFF;
					v.norm = t[31:0];
				end
			end
			v.flat = (qsum == 0);
			v.final_one = (i + 1 == vec_count);
			expected_values.push_back(v);
		end
		vec_count = 0;
		vec_sum = 0;
	endtask

	// quiet stretch: no idling on the input side
	function automatic bit idle_now();
		if (n_accepted >= 150 && n_accepted < 260)
			return 1'b0;
		return $urandom_range(99) < 12;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start       <= 1'b0;
			sample      <= '0;
			last_sample <= 1'b0;
		end else begin
			if (start && !busy) begin
				take_sample(sample, last_sample);
				void'(pending_samples.pop_front());
				n_accepted++;
			end
			if (pending_samples.size() == 0)
				start <= 1'b0;
			else if (pending_samples[0].pause && (expected_values.size() != 0 || busy))
				start <= 1'b0;
			else if (idle_now())
				start <= 1'b0;
			else begin
				start       <= 1'b1;
				sample      <= pending_samples[0].x;
				last_sample <= pending_samples[0].mark;
			end
		end
	end

	always @(posedge clk) begin
		norm_value_t e;
		if (arst_n && valid) begin
			if (expected_values.size() == 0) begin
				$error("unexpected result: normalized %h", normalized);
				n_errors++;
			end else begin
				e = expected_values.pop_front();
				if (normalized !== e.norm) begin
					$error("normalized: expected %h, got %h", e.norm, normalized);
					n_errors++;
				end
				if (zero_spread !== e.flat) begin
					$error("zero_spread: expected %b, got %b", e.flat, zero_spread);
					n_errors++;
				end
				if (last_result !== e.final_one) begin
					$error("last_result: expected %b, got %b", e.final_one, last_result);
					n_errors++;
				end
			end
		end
	end

	task automatic add_sample(logic [31:0] x, logic mark, logic pause = 1'b0);
		sample_item_t s;
		s.x = x;
		s.mark = mark;
		s.pause = pause;
		pending_samples.push_back(s);
	endtask

	function automatic logic [31:0] rand_value(int kind);
		case (kind)
			0: return $urandom;
			1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
			2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom_range(200)) - 100);
		endcase
	endfunction

	initial begin
		int len;
		int kind;
		logic [31:0] base;
		n_errors   = 0;
		n_accepted = 0;
		vec_count  = 0;
		vec_sum    = 0;

		// single sample: zero spread
		add_sample(32'h0001_0000, 1'b1);
		// extremes
		add_sample(32'h7FFF_FFFF, 1'b0);
		add_sample(32'h8000_0000, 1'b1);
		// all equal
		add_sample(32'hFFFF_0000, 1'b0);
		add_sample(32'hFFFF_0000, 1'b0);
		add_sample(32'hFFFF_0000, 1'b1);
		// mixed signs, held until the block has drained
		add_sample(32'h0000_0001, 1'b0, 1'b1);
		add_sample(32'hFFFF_FFFF, 1'b0);
		add_sample(32'h0000_0000, 1'b0);
		add_sample(32'h5555_AAAA, 1'b1);
		// overfull vector: the last two samples are dropped
		for (int i = 0; i < 66; i++)
			add_sample(i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF, i == 65);

		// random vectors, mostly short
		while (pending_samples.size() < 420) begin
			len  = ($urandom_range(19) == 0) ? $urandom_range(66, 40) : $urandom_range(8, 1);
			kind = $urandom_range(4);
			base = rand_value(kind % 4);
			for (int i = 0; i < len; i++)
				add_sample(kind == 4 ? base : rand_value(kind), i == len - 1);
		end

		wait (pending_samples.size() == 0 && expected_values.size() == 0);
		repeat (300) @(posedge clk);
		if (n_errors == 0 && expected_values.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end

endmodule

/* pearson_vector_normalizer_top.f */
sv/pvn_pkg.sv
sv/pvn_divider.sv
sv/pvn_sqrt.sv
sv/pearson_vector_normalizer_top.sv
test/tb_pearson_vector_normalizer_top.sv
